/* hw/rtl/iol_pkg.sv */
// Shared types and codes for the indexed ordered list.
package iol_pkg;

    typedef enum logic [2:0] {
        OP_INS_FRONT = 3'd0,
        OP_INS_END   = 3'd1,
        OP_INS_AT    = 3'd2,
        OP_GET_AT    = 3'd3,
        OP_REM_FRONT = 3'd4,
        OP_REM_END   = 3'd5,
        OP_REM_AT    = 3'd6,
        OP_CLEAR     = 3'd7
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_INDEX = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_WR,
        S_INS_PUT,
        S_FETCH,
        S_CAPTURE,
        S_REM_RD,
        S_REM_WR,
        S_DONE
    } t_state;

    typedef struct packed {
        t_op         operation;
        logic [4:0]  position;
        logic [31:0] item_in;
    } t_in_item;

    typedef struct packed {
        logic [31:0] item_out;
        t_status     status;
        logic [4:0]  item_count;
        logic        list_empty;
    } t_out_item;

    typedef struct packed {
        logic     valid;
        t_in_item item;
    } t_req;

    typedef struct packed {
        logic      valid;
        t_out_item item;
    } t_res;

endpackage

/* hw/rtl/iol_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module iol_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/iol_engine.sv */
// Sequencer that checks a request, shifts entries one at a time and forms the result.
module iol_engine #(
    parameter int CAPACITY  = 16,
    parameter int ITEM_BITS = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  iol_pkg::t_req i_req,
    output logic          o_idle,
    input  logic          i_slot_free,
    output iol_pkg::t_res o_res
);
    import iol_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = (CW > 5) ? CW : 5;

    t_state               r_state, n_state;
    logic [CW-1:0]        r_count, n_count;
    logic [PW-1:0]        r_k, n_k;
    logic [PW-1:0]        r_tgt, n_tgt;
    logic                 r_get, n_get;
    logic [ITEM_BITS-1:0] r_put, n_put;
    logic [ITEM_BITS-1:0] r_got, n_got;
    t_status              r_status, n_status;

    logic                 w_we;
    logic [AW-1:0]        w_waddr;
    logic [AW-1:0]        w_raddr;
    logic [ITEM_BITS-1:0] w_wdata;
    logic [ITEM_BITS-1:0] w_rdata;

    logic [PW-1:0]           w_cnt;
    logic [PW-1:0]           w_pos;
    logic [PW-1:0]           w_tgt;
    logic [PW-1:0]           w_km1;
    logic [PW:0]             w_kp1;
    logic [PW:0]             w_kp2;
    logic [PW:0]             w_tp1;
    logic [PW:0]             w_cnt_x;
    logic [ITEM_BITS+31:0]   w_in_wide;
    logic [ITEM_BITS+31:0]   w_got_wide;

    iol_ram #(
        .WIDTH (ITEM_BITS),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_cnt      = PW'(r_count);
    assign w_cnt_x    = (PW+1)'(r_count);
    assign w_pos      = PW'(i_req.item.position);
    assign w_km1      = r_k - PW'(1);
    assign w_kp1      = (PW+1)'(r_k) + (PW+1)'(1);
    assign w_kp2      = (PW+1)'(r_k) + (PW+1)'(2);
    assign w_tp1      = (PW+1)'(r_tgt) + (PW+1)'(1);
    assign w_in_wide  = {{ITEM_BITS{1'b0}}, i_req.item.item_in};
    assign w_got_wide = {32'd0, r_got};

    always_comb begin
        unique case (i_req.item.operation)
            OP_INS_FRONT, OP_REM_FRONT: w_tgt = '0;
            OP_INS_END:                 w_tgt = w_cnt;
            OP_REM_END:                 w_tgt = w_cnt - PW'(1);
            default:                    w_tgt = w_pos;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
        r_k      <= n_k;
        r_tgt    <= n_tgt;
        r_get    <= n_get;
        r_put    <= n_put;
        r_got    <= n_got;
        r_status <= n_status;
    end

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_k      = r_k;
        n_tgt    = r_tgt;
        n_get    = r_get;
        n_put    = r_put;
        n_got    = r_got;
        n_status = r_status;
        w_we     = 1'b0;
        w_waddr  = r_k[AW-1:0];
        w_raddr  = r_tgt[AW-1:0];
        w_wdata  = w_rdata;
        o_res    = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_tgt    = w_tgt;
                    n_get    = (i_req.item.operation == OP_GET_AT);
                    n_put    = w_in_wide[ITEM_BITS-1:0];
                    n_got    = '0;
                    n_status = ST_OK;
                    n_k      = w_cnt;
                    n_state  = S_DONE;
                    unique case (i_req.item.operation)
                        OP_INS_FRONT, OP_INS_END, OP_INS_AT: begin
                            if (w_tgt > w_cnt) begin
                                n_status = ST_BAD_INDEX;
                            end else if (w_cnt >= PW'(CAPACITY)) begin
                                n_status = ST_FULL;
                            end else if (w_tgt == w_cnt) begin
                                n_state = S_INS_PUT;
                            end else begin
                                n_state = S_INS_RD;
                            end
                        end
                        OP_CLEAR: begin
                            n_count = '0;
                        end
                        default: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                            end else if (w_tgt >= w_cnt) begin
                                n_status = ST_BAD_INDEX;
                            end else begin
                                n_state = S_FETCH;
                            end
                        end
                    endcase
                end
            end
            // insert: move entry k-1 up to k, from the end down to the target
            S_INS_RD: begin
                w_raddr = w_km1[AW-1:0];
                n_state = S_INS_WR;
            end
            S_INS_WR: begin
                w_we    = 1'b1;
                n_k     = w_km1;
                n_state = (w_km1 == r_tgt) ? S_INS_PUT : S_INS_RD;
            end
            S_INS_PUT: begin
                w_we    = 1'b1;
                w_waddr = r_tgt[AW-1:0];
                w_wdata = r_put;
                n_count = r_count + CW'(1);
                n_state = S_DONE;
            end
            S_FETCH: begin
                w_raddr = r_tgt[AW-1:0];
                n_state = S_CAPTURE;
            end
            S_CAPTURE: begin
                n_got = w_rdata;
                n_k   = r_tgt;
                if (r_get) begin
                    n_state = S_DONE;
                end else if (w_tp1 < w_cnt_x) begin
                    n_state = S_REM_RD;
                end else begin
                    n_count = r_count - CW'(1);
                    n_state = S_DONE;
                end
            end
            // remove: move entry k+1 down to k, from the target up to the end
            S_REM_RD: begin
                w_raddr = w_kp1[AW-1:0];
                n_state = S_REM_WR;
            end
            S_REM_WR: begin
                w_we = 1'b1;
                n_k  = w_kp1[PW-1:0];
                if (w_kp2 < w_cnt_x) begin
                    n_state = S_REM_RD;
                end else begin
                    n_count = r_count - CW'(1);
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_slot_free) begin
                    o_res.valid           = 1'b1;
                    o_res.item.item_out   = w_got_wide[31:0];
                    o_res.item.status     = r_status;
                    o_res.item.item_count = 5'(r_count);
                    o_res.item.list_empty = (r_count == '0);
                    n_state               = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_idle = (r_state == S_IDLE);

endmodule

/* hw/rtl/indexed_ordered_list.sv */
// Top level of the indexed ordered list: handshakes, sequencer and result register.
//
//   channel   direction  handshake                   payload
//   in        to block   i_in_valid / o_in_ready     i_in_data  (t_in_item)
//   out       from block o_out_valid / i_out_ready   o_out_data (t_out_item)
//
// One transaction at a time; every step goes through the one RAM port pair.
// Insert moves the entries from the target on up by one, then writes the new item.
// Get reads the target entry; remove reads it, then moves later entries down one.
// A new transaction is taken while a result still waits in the output register.
// Reset empties the list; stored entries are never read before being written.
module indexed_ordered_list #(
    parameter int CAPACITY  = 16,
    parameter int ITEM_BITS = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  iol_pkg::t_in_item   i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output iol_pkg::t_out_item  o_out_data
);
    import iol_pkg::*;

    t_req      w_req;
    t_res      w_res;
    logic      w_idle;
    logic      w_slot_free;
    logic      r_out_valid;
    t_out_item r_out_data;

    assign w_req.valid = i_in_valid;
    assign w_req.item  = i_in_data;
    assign w_slot_free = !r_out_valid || i_out_ready;

    iol_engine #(
        .CAPACITY  (CAPACITY),
        .ITEM_BITS (ITEM_BITS)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (w_req),
        .o_idle      (w_idle),
        .i_slot_free (w_slot_free),
        .o_res       (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res.valid) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (w_res.valid) begin
            r_out_data <= w_res.item;
        end
    end

    assign o_in_ready  = w_idle;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule
